>>> hdl/stbs_pkg.sv
// Shared constants and types for the sorted table binary search block.
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 11;
    localparam int POS_W       = 10;
    localparam int IDX_W       = 10;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]      raddr;
    } t_ram_req;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] index;
    } t_result;

endpackage

>>> hdl/stbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/stbs_seq.sv
// Search sequencer: range registers, midpoint probe and shared compare.
module stbs_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_op,
    input  logic [stbs_pkg::POS_W-1:0]     i_position,
    input  logic [stbs_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic [stbs_pkg::CFG_W-1:0]     i_length,
    input  logic [stbs_pkg::VALUE_WIDTH-1:0] i_rdata,
    output stbs_pkg::t_ram_req             o_ram,
    output stbs_pkg::t_result              o_res,
    input  logic                           i_res_take
);
    import stbs_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [LEN_W-1:0]        r_first;
    logic [LEN_W-1:0]        n_first;
    logic [LEN_W-1:0]        r_end;
    logic [LEN_W-1:0]        n_end;
    logic [ADDR_W-1:0]       r_mid;
    logic [ADDR_W-1:0]       n_mid;
    logic [VALUE_WIDTH-1:0]  r_target;
    logic [VALUE_WIDTH-1:0]  n_target;
    logic                    r_found;
    logic                    n_found;
    logic [IDX_W-1:0]        r_index;
    logic [IDX_W-1:0]        n_index;

    logic                    accept;
    logic                    range_live;
    logic [LEN_W-1:0]        mid_full;
    logic [LEN_W-1:0]        len_sat;
    logic                    probe_eq;
    logic                    probe_gt;

    assign accept     = i_in_valid && o_in_ready;
    assign range_live = r_first < r_end;
    assign mid_full   = r_first + ((r_end - r_first - LEN_W'(1)) >> 1);
    assign len_sat    = (32'(i_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                      : LEN_W'(i_length);
    assign probe_eq   = i_rdata == r_target;
    assign probe_gt   = $signed(i_rdata) > $signed(r_target);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_op == OP_SEARCH) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                n_state = range_live ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                n_state = probe_eq ? ST_DONE : ST_PROBE;
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = ADDR_W'(i_position);
        o_ram.wdata = i_value;
        o_ram.raddr = ADDR_W'(mid_full);
        o_res.valid = 1'b0;
        o_res.found = r_found;
        o_res.index = r_index;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ram.we   = i_in_valid && i_op == OP_LOAD;
            end
            ST_PROBE: begin
            end
            ST_READ: begin
            end
            ST_DONE: begin
                o_res.valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_first  = r_first;
        n_end    = r_end;
        n_mid    = r_mid;
        n_target = r_target;
        n_found  = r_found;
        n_index  = r_index;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_first  = '0;
                    n_end    = len_sat;
                    n_target = i_value;
                end
            end
            ST_PROBE: begin
                n_mid = ADDR_W'(mid_full);
                if (!range_live) begin
                    n_found = 1'b0;
                    n_index = '0;
                end
            end
            ST_READ: begin
                if (probe_eq) begin
                    n_found = 1'b1;
                    n_index = IDX_W'(r_mid);
                end else if (probe_gt) begin
                    n_end = LEN_W'(r_mid);
                end else begin
                    n_first = LEN_W'(r_mid) + LEN_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_first  <= n_first;
        r_end    <= n_end;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_found  <= n_found;
        r_index  <= n_index;
    end

endmodule

>>> hdl/sorted_table_binary_search_top.sv
// Top level of the sorted table binary search block.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser op, tdata position, value
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tuser found, tdata match_index
//  cfg       in         i_cfg_valid/o_cfg_ready          array_length
//
// A load item is written to the RAM in the cycle it is accepted. A search item with
// p probes (at most 11 for 1024 entries) passes ST_PROBE and ST_READ once per probe;
// on a miss a last ST_PROBE finds the range empty. Each probe is one RAM read plus
// one compare. Input is not ready from acceptance of a search until its result is taken.
// The sequencer holds a finished result until the output register is free.
// Reset clears the control state; table contents are undefined until loaded.
module sorted_table_binary_search_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [stbs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // position, value
    input  logic                                i_s_axis_tuser,  // op
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [stbs_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // match_index
    output logic                                o_m_axis_tuser,  // found
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stbs_pkg::CFG_W-1:0]          i_cfg_data       // array_length
);
    import stbs_pkg::*;

    logic [CFG_W-1:0]        r_length;
    logic                    r_out_valid;
    logic                    r_out_found;
    logic [IDX_W-1:0]        r_out_index;
    logic [POS_W-1:0]        in_position;
    logic [VALUE_WIDTH-1:0]  in_value;
    logic [VALUE_WIDTH-1:0]  ram_rdata;
    t_ram_req                ram_req;
    t_result                 res;
    logic                    res_take;

    assign in_position = i_s_axis_tdata[POS_W-1:0];
    assign in_value    = i_s_axis_tdata[POS_W +: VALUE_WIDTH];
    assign o_cfg_ready = 1'b1;
    assign res_take    = res.valid && (!r_out_valid || i_m_axis_tready);

    stbs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    stbs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_op       (i_s_axis_tuser),
        .i_position (in_position),
        .i_value    (in_value),
        .i_length   (r_length),
        .i_rdata    (ram_rdata),
        .o_ram      (ram_req),
        .o_res      (res),
        .i_res_take (res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_length <= i_cfg_data;
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_take) begin
            r_out_found <= res.found;
            r_out_index <= res.index;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_found;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_index);

`ifndef SYNTHESIS
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid && !res_take |=> res.valid)
        else $error("Pending result dropped before the output register took it.");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_index == '0)
        else $error("Not-found result carries a nonzero index.");

    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> !o_s_axis_tready)
        else $error("Input ready while a result is pending.");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_SEARCH
        |=> !o_s_axis_tready)
        else $error("Input ready in the cycle after a search item was accepted.");
`endif

endmodule
